// File: rtl/rfd_pkg.sv
`timescale 1ns / 1ps
package rfd_pkg;

  localparam logic [7:0] HDR_LEN       = 8'd48;
  localparam logic [7:0] LEN_FIELD_POS = 8'd38;
  localparam logic [7:0] POS_MAX       = 8'd255;
  localparam logic [7:0] OPEN_MARK     = 8'h3C;
  localparam logic [7:0] CLOSE_MARK    = 8'h3E;

  // digit parser phases
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // result queue size
  localparam logic [1:0] QDEPTH = 2'd3;

  localparam int unsigned FIELDS_W = 297;
  localparam int unsigned TDATA_W  = 304;

  // first member lands in the top bits; payload_byte ends up in the lowest bits
  typedef struct packed {
    logic [63:0] reserved_bytes;
    logic [47:0] repeater_id_low;
    logic [47:0] repeater_id_high;
    logic [47:0] chip_id_low;
    logic [47:0] chip_id_high;
    logic [6:0]  payload_length;
    logic        encrypted_flag;
    logic [16:0] sequence_count;
    logic [6:0]  message_type;
    logic        frame_valid;
    logic [7:0]  payload_byte;
  } rfd_fields_t;

  typedef struct packed {
    logic        is_summary;
    rfd_fields_t fields;
  } rfd_result_t;

  // up to two results per request, in order
  typedef struct packed {
    logic [1:0]  count;
    rfd_result_t first;
    rfd_result_t second;
  } rfd_push_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] acc;
  } rfd_dec_t;

  function automatic logic rfd_is_digit(input logic [7:0] b);
    rfd_is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic rfd_is_blank(input logic [7:0] b);
    rfd_is_blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // one character of an atoi-style decimal field
  function automatic rfd_dec_t rfd_dec_step(input logic [16:0] acc, input logic [1:0] phase,
                                            input logic [7:0] b);
    rfd_dec_t   r;
    logic [16:0] d;
    d       = {13'd0, b[3:0]};
    r.phase = phase;
    r.acc   = acc;
    if (phase == PH_SKIP) begin
      if (rfd_is_digit(b)) begin
        r.phase = PH_DIGITS;
        r.acc   = d;
      end else if (!rfd_is_blank(b)) begin
        r.phase = PH_DONE;
      end
    end else if (phase == PH_DIGITS) begin
      if (rfd_is_digit(b)) begin
        r.acc = (acc << 3) + (acc << 1) + d;
      end else begin
        r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/rfd_parser.sv
`timescale 1ns / 1ps
module rfd_parser
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [47:0] cfg_wdata,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        is_last,
  output rfd_push_t   push
);

  logic [47:0] chan_r;
  logic [7:0]  pos_r, pos_nxt;
  logic        hm_r, hm_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [6:0]  typ_r, typ_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        enc_r, enc_nxt;
  logic [47:0] id_r [4];
  logic [47:0] id_nxt [4];
  logic [63:0] res_r, res_nxt;

  logic [5:0]  chan_base;
  logic [7:0]  want;
  logic [1:0]  idw;
  logic [7:0]  total;
  logic        frame_ok;
  logic        in_payload;
  rfd_dec_t    dec;
  rfd_result_t pay_res, sum_res;

  assign chan_base  = {3'(3'd5 - pos_r[2:0]), 3'b000};
  assign want       = chan_r[chan_base +: 8];
  assign in_payload = (pos_r >= HDR_LEN);
  assign total      = (pos_r == POS_MAX) ? pos_r : 8'(pos_r + 8'd1);
  assign frame_ok   = hm_r && in_payload && ({1'b0, len_r} == 8'(total - HDR_LEN));

  always_comb begin
    priority if (pos_r < 8'd12) idw = 2'd0;
    else if (pos_r < 8'd18)     idw = 2'd1;
    else if (pos_r < 8'd24)     idw = 2'd2;
    else                        idw = 2'd3;
  end

  always_comb begin
    pos_nxt = pos_r;
    hm_nxt  = hm_r;
    cnt_nxt = cnt_r;
    typ_nxt = typ_r;
    len_nxt = len_r;
    ph_nxt  = ph_r;
    enc_nxt = enc_r;
    res_nxt = res_r;
    for (int i = 0; i < 4; i++) id_nxt[i] = id_r[i];
    dec = '0;

    if (accept) begin
      if (pos_r < 8'd6) begin
        if (rx_byte != want) hm_nxt = 1'b0;
        if (pos_r == 8'd0 && rx_byte != OPEN_MARK) hm_nxt = 1'b0;
        if (pos_r == 8'd5 && rx_byte != CLOSE_MARK) hm_nxt = 1'b0;
      end else if (pos_r < 8'd30) begin
        id_nxt[idw] = {id_r[idw][39:0], rx_byte};
      end else if (pos_r < 8'd35) begin
        // sequence counter, restart at its first byte
        if (pos_r == 8'd30) dec = rfd_dec_step(17'd0, PH_SKIP, rx_byte);
        else                dec = rfd_dec_step(cnt_r, ph_r, rx_byte);
        cnt_nxt = dec.acc;
        ph_nxt  = dec.phase;
      end else if (pos_r == 8'd35) begin
        enc_nxt = rfd_is_digit(rx_byte) && (rx_byte != 8'h30);
      end else if (pos_r < LEN_FIELD_POS) begin
        if (pos_r == 8'd36) dec = rfd_dec_step(17'd0, PH_SKIP, rx_byte);
        else                dec = rfd_dec_step({10'd0, typ_r}, ph_r, rx_byte);
        typ_nxt = dec.acc[6:0];
        ph_nxt  = dec.phase;
      end else if (pos_r < 8'd40) begin
        if (pos_r == LEN_FIELD_POS) dec = rfd_dec_step(17'd0, PH_SKIP, rx_byte);
        else                        dec = rfd_dec_step({10'd0, len_r}, ph_r, rx_byte);
        len_nxt = dec.acc[6:0];
        ph_nxt  = dec.phase;
      end else if (!in_payload) begin
        res_nxt = {res_r[55:0], rx_byte};
      end

      if (pos_r != POS_MAX) pos_nxt = 8'(pos_r + 8'd1);

      // drop packet state after the final byte
      if (is_last) begin
        pos_nxt = '0;
        hm_nxt  = 1'b1;
        cnt_nxt = '0;
        typ_nxt = '0;
        len_nxt = '0;
        ph_nxt  = PH_SKIP;
        enc_nxt = 1'b0;
        res_nxt = '0;
        for (int i = 0; i < 4; i++) id_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    pay_res                     = '0;
    pay_res.fields.payload_byte = rx_byte;

    sum_res            = '0;
    sum_res.is_summary = 1'b1;
    if (frame_ok) begin
      sum_res.fields.frame_valid      = 1'b1;
      sum_res.fields.message_type     = typ_r;
      sum_res.fields.sequence_count   = cnt_r;
      sum_res.fields.encrypted_flag   = enc_r;
      sum_res.fields.payload_length   = len_r;
      sum_res.fields.chip_id_high     = id_r[0];
      sum_res.fields.chip_id_low      = id_r[1];
      sum_res.fields.repeater_id_high = id_r[2];
      sum_res.fields.repeater_id_low  = id_r[3];
      sum_res.fields.reserved_bytes   = res_r;
    end

    push.count  = accept ? 2'({1'b0, in_payload} + {1'b0, is_last}) : 2'd0;
    push.first  = in_payload ? pay_res : sum_res;
    push.second = sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      pos_r  <= '0;
      hm_r   <= 1'b1;
      cnt_r  <= '0;
      typ_r  <= '0;
      len_r  <= '0;
      ph_r   <= PH_SKIP;
      enc_r  <= 1'b0;
      res_r  <= '0;
      for (int i = 0; i < 4; i++) id_r[i] <= '0;
    end else begin
      if (cfg_wen) chan_r <= cfg_wdata;
      pos_r <= pos_nxt;
      hm_r  <= hm_nxt;
      cnt_r <= cnt_nxt;
      typ_r <= typ_nxt;
      len_r <= len_nxt;
      ph_r  <= ph_nxt;
      enc_r <= enc_nxt;
      res_r <= res_nxt;
      for (int i = 0; i < 4; i++) id_r[i] <= id_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> pos_r == 8'd0 && hm_r)
    else $error("packet state not cleared after final byte");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_last && pos_r == POS_MAX |=> pos_r == POS_MAX)
    else $error("byte position wrapped past saturation");
`endif

endmodule

// File: rtl/rfd_outq.sv
`timescale 1ns / 1ps
module rfd_outq
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rfd_push_t   push,
  output logic        room,
  output logic        head_valid,
  input  logic        head_ready,
  output rfd_result_t head
);

  rfd_result_t slot_r [3];
  logic [1:0]  wr_r, wr_nxt;
  logic [1:0]  rd_r, rd_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  wr_p1;
  logic        pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    inc3 = (p == QDEPTH - 2'd1) ? 2'd0 : 2'(p + 2'd1);
  endfunction

  assign wr_p1      = inc3(wr_r);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = slot_r[rd_r];
  assign pop        = head_valid && head_ready;
  // room for two results regardless of this cycle's pop
  assign room       = (cnt_r <= 2'd1);

  always_comb begin
    wr_nxt  = wr_r;
    if (push.count == 2'd1) wr_nxt = wr_p1;
    if (push.count == 2'd2) wr_nxt = inc3(wr_p1);
    rd_nxt  = pop ? inc3(rd_r) : rd_r;
    cnt_nxt = 2'(cnt_r + push.count - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slot_r[wr_r] <= push.first;
    if (push.count == 2'd2) slot_r[wr_p1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + {1'b0, push.count}) <= 3'd3)
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.count == 2'd0 |=> cnt_r == 2'($past(cnt_r) - 2'd1))
    else $error("queue count did not drop on pop");
`endif

endmodule

// File: rtl/ascii_radio_frame_deframer.sv
`timescale 1ns / 1ps
// ASCII radio frame deframer.
// in_*  : one received packet byte per request, in_tlast on the final byte.
// out_* : results; out_tuser = 0 carries a payload byte (packet byte 48 on),
//         out_tuser = 1 carries the end of packet summary with the decoded
//         48-byte header (all zero but the flag when a check fails).
// cfg_* : the six-byte channel id expected at the frame start, byte 0 in the
//         top bits; write it while no packet is in flight.
// Each request is parsed in the cycle it is accepted and its results are
// registered in a three-entry result queue, from whose head they show on
// out_*. One byte is taken every cycle while the receiver keeps up; a final
// byte inside the payload yields two results (payload then summary), and the
// queue then drops in_tready while the extra result drains.
// When the receiver stalls, held results stay on out_* and in_tready falls
// once two results are waiting, so nothing is lost.
// Reset clears the packet parser, the channel id and the result queue; the
// block takes requests as soon as reset is released.
module ascii_radio_frame_deframer
  import rfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wen,
  input  logic [47:0]          cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] rx_byte
  input  logic                 in_tlast,    // is_last
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] payload_byte, [8] frame_valid, [15:9] message_type,
  // [32:16] sequence_count, [33] encrypted_flag, [40:34] payload_length,
  // [88:41] chip_id_high, [136:89] chip_id_low, [184:137] repeater_id_high,
  // [232:185] repeater_id_low, [296:233] reserved_bytes, [303:297] zero
  output logic [TDATA_W-1:0]   out_tdata,
  output logic                 out_tuser    // is_summary
);

  logic        accept;
  rfd_push_t   push;
  logic        room;
  rfd_result_t head;

  // advance the parser only on an accepted request
  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  rfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .is_last   (in_tlast),
    .push      (push)
  );

  // hold results here until the receiver takes them
  rfd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {(TDATA_W - FIELDS_W)'(0), head.fields};
  assign out_tuser = head.is_summary;

`ifndef SYNTHESIS
  a_payload_only_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[TDATA_W-1:8] == '0)
    else $error("payload result carries header fields");

  a_invalid_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tdata[8] |-> out_tdata == '0)
    else $error("failed summary carries nonzero fields");
`endif

endmodule
